FILE: rtl/strided_index_converter_unit_assert.svh
// Assertion macros shared by the strided index converter RTL.
// Expects a signal named clock and a signal named reset in the including scope.
`ifndef STRIDED_INDEX_CONVERTER_UNIT_ASSERT_SVH
`define STRIDED_INDEX_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("strided index converter: assertion failed");

// Next-cycle implication, checked outside reset.
`define SIC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("strided index converter: assertion failed");

`endif

FILE: rtl/sic_pkg.sv
// Shared types and constants of the strided index converter.
// No dependencies; used by sic_div and strided_index_converter_unit.
package sic_pkg;

   localparam int NUM_COORD  = 4;
   localparam int COORD_W    = 16;
   localparam int EXTENT_W   = 16;
   localparam int STRIDE_W   = 32;
   localparam int FLAT_W     = 32;
   localparam int CFG_W      = 3;
   localparam int RANGE_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_CNT_W  = 5;

   localparam logic [CFG_W-1:0]     NUM_DIMS_RESET = 3'd1;
   localparam logic                 REG_NUM_DIMS   = 1'b0;
   localparam logic [COORD_W-1:0]   COORD_MAX      = 16'hFFFF;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP  = 5'd31;

   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_RAVEL   = 2'd1;
   localparam logic [1:0] CMD_UNRAVEL = 2'd2;

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_END         = 2'd1;
   localparam logic [1:0] ERR_RANGE       = 2'd2;
   localparam logic [1:0] ERR_ZERO_STRIDE = 2'd3;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [1:0]          dim_sel;
      logic [EXTENT_W-1:0] extent_in;
      logic [STRIDE_W-1:0] stride_in;
      logic [COORD_W-1:0]  coord_in_0;
      logic [COORD_W-1:0]  coord_in_1;
      logic [COORD_W-1:0]  coord_in_2;
      logic [COORD_W-1:0]  coord_in_3;
      logic [RANGE_W-1:0]  range_start;
      logic [RANGE_W-1:0]  range_end;
      logic [FLAT_W-1:0]   flat_in;
   } req_type;

   typedef struct packed {
      logic [FLAT_W-1:0]  flat_out;
      logic [COORD_W-1:0] coord_out_0;
      logic [COORD_W-1:0] coord_out_1;
      logic [COORD_W-1:0] coord_out_2;
      logic [COORD_W-1:0] coord_out_3;
      logic [1:0]         error_code;
      logic [1:0]         error_dim;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAV_MUL,
      ST_RAV_ACC,
      ST_UNR_NEXT,
      ST_UNR_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                start;
      logic [FLAT_W-1:0]   dividend;
      logic [STRIDE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [FLAT_W-1:0]   quot;
      logic [STRIDE_W-1:0] rem;
   } div_rsp_type;

endpackage

FILE: rtl/sic_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on sic_pkg for the request and response structs.
module sic_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sic_pkg::div_req_type div_req,
   output sic_pkg::div_rsp_type div_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [sic_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [sic_pkg::FLAT_W-1:0]       quot_ff, quot_in;
   logic [sic_pkg::STRIDE_W-1:0]     rem_ff, rem_in;
   logic [sic_pkg::STRIDE_W-1:0]     divisor_ff, divisor_in;
   logic [sic_pkg::STRIDE_W:0]       shifted;
   logic [sic_pkg::STRIDE_W:0]       diff;
   logic                             fits;

   // The partial remainder stays below the divisor, so one extra bit covers the shift.
   assign shifted = {rem_ff, quot_ff[sic_pkg::FLAT_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[sic_pkg::STRIDE_W-1:0] : shifted[sic_pkg::STRIDE_W-1:0];
         quot_in = {quot_ff[sic_pkg::FLAT_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == sic_pkg::DIV_LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

FILE: rtl/strided_index_converter_unit.sv
// Strided index converter: per-dimension extent/stride table, ravel and unravel sequencer.
// Depends on sic_pkg, sic_div and strided_index_converter_unit_assert.svh.
//
//   Channel  Direction  Handshake                 Payload
//   req_     in         req_valid / req_ready     sic_pkg::req_type
//   rsp_     out        rsp_valid / rsp_ready     sic_pkg::rsp_type
//   csr_     in         APB write/read, pready=1  num_dims at byte address 0
//
// One transaction at a time; req_ready is high only while the sequencer is idle.
// Table write, unused command and range-end error go straight to the done state.
// Ravel steps a multiply and an accumulate state per dimension. Unravel starts the
// divider and waits for it per nonzero-stride dimension; zero strides are skipped.
// Synchronous reset clears the table, sets num_dims to 1; no clearing pass is needed.
// A finished result waits in the sequencer while the output register is still held.
`include "strided_index_converter_unit_assert.svh"

module strided_index_converter_unit #(
   parameter int MAX_DIMS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sic_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sic_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sic_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sic_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sic_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_W = ($clog2(MAX_DIMS + 1) > 3) ? $clog2(MAX_DIMS + 1) : 3;

   sic_pkg::state_type               state_ff, state_in;
   sic_pkg::req_type                 req_ff;
   sic_pkg::rsp_type                 res_ff, res_in;
   sic_pkg::rsp_type                 rsp_data_ff;
   logic                             rsp_valid_ff;
   logic [CNT_W-1:0]                 idx_ff, idx_in;
   logic [sic_pkg::FLAT_W-1:0]       sum_ff, sum_in;
   logic [sic_pkg::FLAT_W-1:0]       prod_ff, prod_in;
   logic [sic_pkg::FLAT_W-1:0]       rem_ff, rem_in;
   logic [sic_pkg::CFG_W-1:0]        num_dims_ff;
   logic [sic_pkg::EXTENT_W-1:0]     extent_ff [MAX_DIMS];
   logic [sic_pkg::STRIDE_W-1:0]     stride_ff [MAX_DIMS];

   sic_pkg::div_req_type             div_req;
   sic_pkg::div_rsp_type             div_rsp;

   logic                             req_fire;
   logic                             rsp_load;
   logic                             tbl_we;
   logic                             csr_write;
   logic [CNT_W-1:0]                 dims_eff;
   logic                             idx_in_table;
   logic                             rav_more;
   logic                             start_end_bad;
   logic [sic_pkg::EXTENT_W-1:0]     ext_sel;
   logic [sic_pkg::STRIDE_W-1:0]     str_sel;
   logic [sic_pkg::COORD_W-1:0]      coord_sel;
   logic                             quot_sat;
   logic [sic_pkg::COORD_W-1:0]      quot_coord;

   sic_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[sic_pkg::CSR_ADDR_W-1:2] == sic_pkg::REG_NUM_DIMS)
                       ? sic_pkg::CSR_DATA_W'(num_dims_ff) : '0;

   assign dims_eff = (CNT_W'(num_dims_ff) > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS)
                                                              : CNT_W'(num_dims_ff);

   assign req_ready = (state_ff == sic_pkg::ST_IDLE) && !reset;
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == sic_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign start_end_bad = CNT_W'(req_data.range_end) > dims_eff;

   // Table lookups at the current dimension; out-of-table dimensions read as zero.
   assign idx_in_table = idx_ff < CNT_W'(MAX_DIMS);
   assign ext_sel = idx_in_table ? extent_ff[idx_ff[DIM_W-1:0]] : '0;
   assign str_sel = idx_in_table ? stride_ff[idx_ff[DIM_W-1:0]] : '0;
   assign rav_more = (idx_ff < CNT_W'(req_ff.range_end)) && idx_in_table;

   always_comb begin
      coord_sel = '0;
      if (idx_ff < CNT_W'(sic_pkg::NUM_COORD)) begin
         unique case (idx_ff[1:0])
            2'd0: coord_sel = req_ff.coord_in_0;
            2'd1: coord_sel = req_ff.coord_in_1;
            2'd2: coord_sel = req_ff.coord_in_2;
            2'd3: coord_sel = req_ff.coord_in_3;
         endcase
      end
   end

   assign quot_sat   = |div_rsp.quot[sic_pkg::FLAT_W-1:sic_pkg::COORD_W];
   assign quot_coord = quot_sat ? sic_pkg::COORD_MAX : div_rsp.quot[sic_pkg::COORD_W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sic_pkg::ST_IDLE: begin
            if (req_fire) begin
               priority if (req_data.cmd == sic_pkg::CMD_RAVEL) begin
                  state_in = start_end_bad ? sic_pkg::ST_DONE : sic_pkg::ST_RAV_MUL;
               end else if (req_data.cmd == sic_pkg::CMD_UNRAVEL) begin
                  state_in = sic_pkg::ST_UNR_NEXT;
               end else begin
                  state_in = sic_pkg::ST_DONE;
               end
            end
         end
         sic_pkg::ST_RAV_MUL: begin
            priority if (!rav_more) begin
               state_in = sic_pkg::ST_DONE;
            end else if (coord_sel >= ext_sel) begin
               state_in = sic_pkg::ST_DONE;
            end else begin
               state_in = sic_pkg::ST_RAV_ACC;
            end
         end
         sic_pkg::ST_RAV_ACC: begin
            state_in = sic_pkg::ST_RAV_MUL;
         end
         sic_pkg::ST_UNR_NEXT: begin
            priority if (idx_ff >= dims_eff) begin
               state_in = sic_pkg::ST_DONE;
            end else if (str_sel == '0) begin
               state_in = sic_pkg::ST_UNR_NEXT;
            end else begin
               state_in = sic_pkg::ST_UNR_WAIT;
            end
         end
         sic_pkg::ST_UNR_WAIT: begin
            if (div_rsp.done) begin
               state_in = sic_pkg::ST_UNR_NEXT;
            end
         end
         sic_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = sic_pkg::ST_IDLE;
            end
         end
         default: state_in = sic_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and next values.
   always_comb begin
      res_in           = res_ff;
      idx_in           = idx_ff;
      sum_in           = sum_ff;
      prod_in          = prod_ff;
      rem_in           = rem_ff;
      tbl_we           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = rem_ff;
      div_req.divisor  = str_sel;
      unique case (state_ff)
         sic_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_in = '0;
               idx_in = '0;
               sum_in = '0;
               rem_in = req_data.flat_in;
               tbl_we = (req_data.cmd == sic_pkg::CMD_WRITE) &&
                        (32'(req_data.dim_sel) < MAX_DIMS);
               if (req_data.cmd == sic_pkg::CMD_RAVEL) begin
                  idx_in = CNT_W'(req_data.range_start);
                  if (start_end_bad) begin
                     res_in.error_code = sic_pkg::ERR_END;
                  end
               end
            end
         end
         sic_pkg::ST_RAV_MUL: begin
            priority if (!rav_more) begin
               res_in.flat_out = sum_ff;
            end else if (coord_sel >= ext_sel) begin
               res_in.error_code = sic_pkg::ERR_RANGE;
               res_in.error_dim  = idx_ff[1:0];
            end else begin
               prod_in = sic_pkg::FLAT_W'(coord_sel * str_sel);
            end
         end
         sic_pkg::ST_RAV_ACC: begin
            sum_in = sum_ff + prod_ff;
            idx_in = idx_ff + 1'b1;
         end
         sic_pkg::ST_UNR_NEXT: begin
            if (idx_ff < dims_eff) begin
               if (str_sel == '0) begin
                  // Coordinate stays zero and the offset passes on unchanged.
                  if (res_ff.error_code == sic_pkg::ERR_NONE) begin
                     res_in.error_code = sic_pkg::ERR_ZERO_STRIDE;
                     res_in.error_dim  = idx_ff[1:0];
                  end
                  idx_in = idx_ff + 1'b1;
               end else begin
                  div_req.start = 1'b1;
               end
            end
         end
         sic_pkg::ST_UNR_WAIT: begin
            if (div_rsp.done) begin
               if (quot_sat && (res_ff.error_code == sic_pkg::ERR_NONE)) begin
                  res_in.error_code = sic_pkg::ERR_RANGE;
                  res_in.error_dim  = idx_ff[1:0];
               end
               if (idx_ff < CNT_W'(sic_pkg::NUM_COORD)) begin
                  unique case (idx_ff[1:0])
                     2'd0: res_in.coord_out_0 = quot_coord;
                     2'd1: res_in.coord_out_1 = quot_coord;
                     2'd2: res_in.coord_out_2 = quot_coord;
                     2'd3: res_in.coord_out_3 = quot_coord;
                  endcase
               end
               rem_in = div_rsp.rem;
               idx_in = idx_ff + 1'b1;
            end
         end
         sic_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sic_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         num_dims_ff  <= sic_pkg::NUM_DIMS_RESET;
         for (int i = 0; i < MAX_DIMS; i++) begin
            extent_ff[i] <= '0;
            stride_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write && (csr_paddr[sic_pkg::CSR_ADDR_W-1:2] == sic_pkg::REG_NUM_DIMS)) begin
            num_dims_ff <= csr_pwdata[sic_pkg::CFG_W-1:0];
         end
         if (tbl_we) begin
            extent_ff[DIM_W'(req_data.dim_sel)] <= req_data.extent_in;
            stride_ff[DIM_W'(req_data.dim_sel)] <= req_data.stride_in;
         end
      end
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
      res_ff  <= res_in;
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The divider is only started on a nonzero stride.
   `SIC_ASSERT_NOW(a_div_nonzero, div_req.start, (div_req.divisor != '0))
   // A finished division only arrives while the sequencer waits for it.
   `SIC_ASSERT_NOW(a_div_done_wait, div_rsp.done, (state_ff == sic_pkg::ST_UNR_WAIT))
   // A range-end error carries no offset and points at dimension zero.
   `SIC_ASSERT_NOW(a_end_err_clean,
      rsp_valid_ff && (rsp_data_ff.error_code == sic_pkg::ERR_END),
      (rsp_data_ff.flat_out == '0) && (rsp_data_ff.error_dim == '0))
   // Loading the output register always completes the transaction in progress.
   `SIC_ASSERT_NEXT(a_load_idle, rsp_load, (state_ff == sic_pkg::ST_IDLE) && rsp_valid_ff)

endmodule

FILE: tb/sv/tb_strided_index_converter_unit.sv
// Self-checking testbench for strided_index_converter_unit: directed and random
// ravel, unravel and table-write traffic checked against an in-bench predictor.
// Depends on sic_pkg and the strided_index_converter_unit RTL.
module tb_strided_index_converter_unit;
   import sic_pkg::*;

   localparam int MAX_DIMS = 4;
   localparam int MAX_REPORTS = 40;
   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] NUM_DIMS_ADDR = CSR_ADDR_W'(4 * REG_NUM_DIMS);

   typedef enum int {SINK_STREAM, SINK_COIN, SINK_SPARSE, SINK_BURSTY} sink_mode_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Shadow of the block's table and dimension count, updated by table and num_dims writes.
   logic [EXTENT_W-1:0] extent_shadow [MAX_DIMS];
   logic [STRIDE_W-1:0] stride_shadow [MAX_DIMS];
   logic [CFG_W-1:0] dims_shadow;

   rsp_type predicted_results [$];
   int error_count = 0;
   int unsigned burst_left = 0;
   int unsigned rsp_hold_request = 0;

   strided_index_converter_unit #(.MAX_DIMS(MAX_DIMS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int unsigned active_dims();
      return (dims_shadow > MAX_DIMS) ? MAX_DIMS : dims_shadow;
   endfunction

   // Expected result of one accepted transaction; table writes update the shadow.
   function automatic rsp_type convert_index(input req_type item);
      rsp_type r;
      int unsigned dims;
      int i;
      logic hit;
      logic [FLAT_W-1:0] sum;
      logic [FLAT_W-1:0] rem;
      logic [FLAT_W-1:0] q;
      logic [3:0][COORD_W-1:0] coords;
      logic [3:0][COORD_W-1:0] q_out;
      r = '0;
      dims = active_dims();
      q_out = '0;
      case (item.cmd)
         CMD_WRITE: begin
            extent_shadow[item.dim_sel] = item.extent_in;
            stride_shadow[item.dim_sel] = item.stride_in;
         end
         CMD_RAVEL: begin
            coords = {item.coord_in_3, item.coord_in_2, item.coord_in_1, item.coord_in_0};
            sum = '0;
            hit = 1'b0;
            if (item.range_end > dims) begin
               r.error_code = ERR_END;
            end else begin
               for (i = int'(item.range_start); i < item.range_end && i < MAX_DIMS && !hit;
                    i++) begin
                  if (coords[i] >= extent_shadow[i]) begin
                     r.error_code = ERR_RANGE;
                     r.error_dim = i[1:0];
                     sum = '0;
                     hit = 1'b1;
                  end else begin
                     sum = sum + coords[i] * stride_shadow[i];
                  end
               end
            end
            r.flat_out = sum;
         end
         CMD_UNRAVEL: begin
            rem = item.flat_in;
            for (i = 0; i < dims; i++) begin
               q = '0;
               if (stride_shadow[i] == 0) begin
                  // The offset passes through a zero stride untouched.
                  if (r.error_code == ERR_NONE) begin
                     r.error_code = ERR_ZERO_STRIDE;
                     r.error_dim = i[1:0];
                  end
               end else begin
                  q = rem / stride_shadow[i];
                  rem = rem % stride_shadow[i];
                  if (q > COORD_MAX) begin
                     q = COORD_MAX;
                     if (r.error_code == ERR_NONE) begin
                        r.error_code = ERR_RANGE;
                        r.error_dim = i[1:0];
                     end
                  end
               end
               q_out[i] = q[COORD_W-1:0];
            end
            r.coord_out_0 = q_out[0];
            r.coord_out_1 = q_out[1];
            r.coord_out_2 = q_out[2];
            r.coord_out_3 = q_out[3];
         end
         default: ;
      endcase
      return r;
   endfunction

   // Random content in every field, so unused fields are exercised too.
   function automatic req_type noise_item();
      logic [159:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic req_type write_item(input logic [1:0] dim, input logic [EXTENT_W-1:0] ext,
                                          input logic [STRIDE_W-1:0] str);
      req_type r;
      r = noise_item();
      r.cmd = CMD_WRITE;
      r.dim_sel = dim;
      r.extent_in = ext;
      r.stride_in = str;
      return r;
   endfunction

   function automatic req_type ravel_item(input logic [COORD_W-1:0] c0, c1, c2, c3,
                                          input logic [RANGE_W-1:0] first, last);
      req_type r;
      r = noise_item();
      r.cmd = CMD_RAVEL;
      r.coord_in_0 = c0;
      r.coord_in_1 = c1;
      r.coord_in_2 = c2;
      r.coord_in_3 = c3;
      r.range_start = first;
      r.range_end = last;
      return r;
   endfunction

   function automatic req_type unravel_item(input logic [FLAT_W-1:0] flat);
      req_type r;
      r = noise_item();
      r.cmd = CMD_UNRAVEL;
      r.flat_in = flat;
      return r;
   endfunction

   // Mostly legal coordinates and offsets for the current table, with some noise mixed in.
   function automatic req_type random_index_item();
      req_type r;
      int unsigned pick;
      int unsigned dims;
      int unsigned first;
      int d;
      longint unsigned span;
      logic [3:0][COORD_W-1:0] c;
      dims = active_dims();
      pick = $urandom_range(99);
      r = noise_item();
      if (pick < 4) begin
         r.cmd = CMD_WRITE;
      end else if (pick < 8) begin
         r.cmd = CMD_RESERVED;
      end else if (pick < 52) begin
         r.cmd = CMD_RAVEL;
         if ($urandom_range(9) < 8) begin
            first = $urandom_range(dims);
            r.range_start = first[RANGE_W-1:0];
            r.range_end = RANGE_W'($urandom_range(dims, first));
         end
         for (d = 0; d < 4; d++) begin
            if (extent_shadow[d] != 0 && $urandom_range(9) != 0)
               c[d] = COORD_W'($urandom_range(extent_shadow[d] - 1));
            else
               c[d] = COORD_W'($urandom);
         end
         r.coord_in_0 = c[0];
         r.coord_in_1 = c[1];
         r.coord_in_2 = c[2];
         r.coord_in_3 = c[3];
      end else begin
         r.cmd = CMD_UNRAVEL;
         span = longint'(extent_shadow[0]) * longint'(stride_shadow[0]);
         if (span != 0 && span <= 64'h1_0000_0000 && $urandom_range(4) != 0)
            r.flat_in = $urandom_range(32'(span - 1));
      end
      return r;
   endfunction

   // Holds the transaction until accepted, then records its expected result.
   task automatic issue_request(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predicted_results.push_back(convert_index(item));
   endtask

   task automatic sender_pace();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_results.size() != 0);
   endtask

   task automatic write_num_dims(input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] upper;
      upper = $urandom;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= NUM_DIMS_ADDR;
      // Only the low bits hold the count; the rest of the word is don't-care.
      csr_pwdata <= {upper[CSR_DATA_W-1:CFG_W], value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      dims_shadow = value;
   endtask

   // Row-major shape over all four entries: the last dimension varies fastest.
   task automatic program_shape();
      logic [EXTENT_W-1:0] ext;
      logic [STRIDE_W-1:0] str;
      int d;
      int unsigned pick;
      str = ($urandom_range(5) == 0) ? $urandom_range(2, 5) : 1;
      for (d = MAX_DIMS - 1; d >= 0; d--) begin
         pick = $urandom_range(99);
         if (pick < 80) ext = EXTENT_W'($urandom_range(1, 12));
         else if (pick < 97) ext = EXTENT_W'($urandom_range(13, 300));
         else ext = EXTENT_W'($urandom);
         issue_request(write_item(d[1:0], ext, str));
         sender_pace();
         str = str * ext;
      end
   endtask

   task automatic test_reset_state();
      // Table is all zero and one dimension is active after reset.
      issue_request(unravel_item(32'hFFFF_FFFF));
      issue_request(ravel_item(16'd0, 16'd0, 16'd0, 16'd0, 3'd0, 3'd1));
      issue_request(ravel_item(16'd0, 16'd0, 16'd0, 16'd0, 3'd0, 3'd0));
      issue_request(ravel_item(16'd0, 16'd0, 16'd0, 16'd0, 3'd0, 3'd2));
      begin
         req_type r;
         r = noise_item();
         r.cmd = CMD_RESERVED;
         issue_request(r);
      end
      wait_results_drained();
   endtask

   task automatic test_directed_cases();
      req_type r;
      write_num_dims(3'd4);
      issue_request(write_item(2'd0, 16'hFFFF, 32'hFFFF_FFFF));
      issue_request(write_item(2'd1, 16'd1, 32'h0001_0000));
      issue_request(write_item(2'd2, 16'h8000, 32'd0));
      issue_request(write_item(2'd3, 16'hFFFF, 32'd1));
      // Top legal coordinates with a huge stride: the sum wraps modulo 2^32.
      issue_request(ravel_item(16'hFFFE, 16'd0, 16'h7FFF, 16'hFFFE, 3'd0, 3'd4));
      // Dimensions 1 and 3 are both out of range; only the first one is reported.
      issue_request(ravel_item(16'd0, 16'd1, 16'd0, 16'hFFFF, 3'd0, 3'd4));
      issue_request(ravel_item(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 3'd3, 3'd4));
      issue_request(ravel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd4, 3'd4));
      issue_request(ravel_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 3'd2));
      issue_request(ravel_item(16'd0, 16'd0, 16'd0, 16'd0, 3'd0, 3'd5));
      issue_request(ravel_item(16'd0, 16'd0, 16'd0, 16'd0, 3'd7, 3'd7));
      issue_request(unravel_item(32'hFFFF_FFFF));
      issue_request(unravel_item(32'hFFFF_FFFE));
      issue_request(unravel_item(32'd0));
      // Unit stride on dimension 0 saturates; the later zero stride must not override it.
      issue_request(write_item(2'd0, 16'd0, 32'd1));
      issue_request(unravel_item(32'h1234_5678));
      issue_request(ravel_item(16'd0, 16'd0, 16'd0, 16'd0, 3'd0, 3'd1));
      r = noise_item();
      r.cmd = CMD_RESERVED;
      issue_request(r);
      wait_results_drained();
   endtask

   task automatic test_num_dims_sweep();
      logic [CFG_W-1:0] sweep_order [8];
      int s;
      int n;
      sweep_order = '{3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6};
      program_shape();
      for (s = 0; s < 8; s++) begin
         wait_results_drained();
         write_num_dims(sweep_order[s]);
         for (n = 0; n < 12; n++) begin
            issue_request(random_index_item());
            sender_pace();
         end
      end
      wait_results_drained();
   endtask

   task automatic test_output_backpressure();
      int n;
      // The sink holds off long enough for the block to fill and stall its input.
      rsp_hold_request = 400;
      for (n = 0; n < 24; n++)
         issue_request(random_index_item());
      wait_results_drained();
   endtask

   task automatic test_random_traffic();
      int phase;
      int n;
      int unsigned pick;
      for (phase = 0; phase < 10; phase++) begin
         wait_results_drained();
         pick = $urandom_range(9);
         write_num_dims((pick < 8) ? CFG_W'($urandom_range(1, 4)) : CFG_W'($urandom));
         program_shape();
         for (n = 0; n < 100; n++) begin
            issue_request(random_index_item());
            sender_pace();
         end
      end
   endtask

   // Result sink: switches between stall patterns and honors long hold-off requests.
   initial begin : rsp_sink
      sink_mode_type mode;
      int unsigned mode_left;
      int unsigned hold_left;
      mode = SINK_STREAM;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (mode_left == 0) begin
            mode = sink_mode_type'($urandom_range(3));
            mode_left = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               SINK_STREAM: rsp_ready <= 1'b1;
               SINK_COIN:   rsp_ready <= ($urandom_range(1) != 0);
               SINK_SPARSE: rsp_ready <= ($urandom_range(3) == 0);
               default:     rsp_ready <= mode_left[2];
            endcase
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected transaction, expected none, actual %0h", $time, rsp_data);
         end else begin
            want = predicted_results.pop_front();
            check_field("flat_out", want.flat_out, rsp_data.flat_out);
            check_field("coord_out_0", 32'(want.coord_out_0), 32'(rsp_data.coord_out_0));
            check_field("coord_out_1", 32'(want.coord_out_1), 32'(rsp_data.coord_out_1));
            check_field("coord_out_2", 32'(want.coord_out_2), 32'(rsp_data.coord_out_2));
            check_field("coord_out_3", 32'(want.coord_out_3), 32'(rsp_data.coord_out_3));
            check_field("error_code", 32'(want.error_code), 32'(rsp_data.error_code));
            check_field("error_dim", 32'(want.error_dim), 32'(rsp_data.error_dim));
         end
      end
   end

   initial begin
      int d;
      for (d = 0; d < MAX_DIMS; d++) begin
         extent_shadow[d] = '0;
         stride_shadow[d] = '0;
      end
      dims_shadow = NUM_DIMS_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_cases();
      test_num_dims_sweep();
      test_output_backpressure();
      test_random_traffic();
      wait_results_drained();
      repeat (40) @(posedge clock);
      if (predicted_results.size() != 0)
         $display("%0t: %0d transactions never returned, expected 0, actual %0d", $time,
                  predicted_results.size(), predicted_results.size());
      if (error_count == 0 && predicted_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
